// File: rtl/rs485_rx_fifo_with_trace_log_top_macros.svh
// ----------------------------------------------------------------------------
// rs485 rx fifo with trace log - assertion macros
// shared concurrent assertion forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef RS485_RX_FIFO_WITH_TRACE_LOG_TOP_MACROS_SVH
`define RS485_RX_FIFO_WITH_TRACE_LOG_TOP_MACROS_SVH

// same-cycle implication under active-low reset
`define RXTL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under active-low reset
`define RXTL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rxtl_pkg.sv
// ----------------------------------------------------------------------------
// rxtl_pkg
// types and codes shared by the rs485 receive ring and trace log
// ----------------------------------------------------------------------------
package rxtl_pkg;

    localparam int CNT_W  = 32;
    localparam int BYTE_W = 8;
    localparam int ACT_W  = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_RX_BYTE   = 4'd0,
        ACT_TX_BYTE   = 4'd1,
        ACT_TX_FEND   = 4'd2,
        ACT_RX_FEND   = 4'd3,
        ACT_READ      = 4'd4,
        ACT_FLUSH     = 4'd5,
        ACT_POP_EVENT = 4'd6,
        ACT_POP_DATA  = 4'd7,
        ACT_CLR_OVF   = 4'd8
    } t_action;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RXRD   = 5'b00010,
        S_TRRD   = 5'b00100,
        S_TRDATA = 5'b01000,
        S_RESP   = 5'b10000
    } t_state;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_FEND = 1'b1;

    typedef struct packed {
        logic              kind;
        logic              is_tx;
        logic [BYTE_W-1:0] data;
    } t_trace_entry;

    typedef struct packed {
        logic              ok;
        logic [BYTE_W-1:0] byte_out;
        logic              event_kind;
        logic              event_is_tx;
        logic [CNT_W-1:0]  overflow_count;
        logic [CNT_W-1:0]  received_count;
    } t_result;

endpackage

// File: rtl/rxtl_if.sv
// ----------------------------------------------------------------------------
// rxtl channel interfaces
// valid/ready channels for action beats and result beats
// ----------------------------------------------------------------------------
interface rxtl_in_if;
    logic                          valid;
    logic                          ready;
    logic [rxtl_pkg::ACT_W-1:0]    action;
    logic [rxtl_pkg::BYTE_W-1:0]   byte_value;
    logic                          transmit_window;

    modport source (output valid, action, byte_value, transmit_window, input ready);
    modport sink   (input valid, action, byte_value, transmit_window, output ready);
endinterface

interface rxtl_out_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [rxtl_pkg::BYTE_W-1:0]   byte_out;
    logic                          event_kind;
    logic                          event_is_tx;
    logic [rxtl_pkg::CNT_W-1:0]    overflow_count;
    logic [rxtl_pkg::CNT_W-1:0]    received_count;

    modport source (output valid, ok, byte_out, event_kind, event_is_tx,
                    overflow_count, received_count, input ready);
    modport sink   (input valid, ok, byte_out, event_kind, event_is_tx,
                    overflow_count, received_count, output ready);
endinterface

// File: rtl/rs485_rx_fifo_with_trace_log_top.sv
// ----------------------------------------------------------------------------
// rs485_rx_fifo_with_trace_log_top
// receive byte ring with overflow and arrival counters, plus a trace ring of
// rx/tx data and frame-end events that drops its oldest entry when full
// ----------------------------------------------------------------------------
// One action beat is worked at a time and gives one result beat. Line bytes,
// logged tx bytes, frame ends, flush and overflow clear go through the beat
// cycle, which does all ram writes and pointer updates, and then a result
// cycle that loads the output register. A read or an event pop that finds an
// item passes one more state (S_RXRD or S_TRRD) for the registered read port
// of the ring's ram; on an empty ring it goes straight to the result cycle. A
// data pop stays in S_TRDATA for each trace entry it reads (frame ends it
// discards plus the data entry), one trace ram read per cycle. A new beat is
// taken while the previous result still waits in the output register; the
// result cycle stalls only if that register is still full.
module rs485_rx_fifo_with_trace_log_top #(
    parameter int RX_DEPTH    = 2048,
    parameter int TRACE_DEPTH = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rxtl_in_if.sink           i_in,
    rxtl_out_if.source        o_out
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TR_AW = $clog2(TRACE_DEPTH);
    localparam int TR_W  = $bits(rxtl_pkg::t_trace_entry);

    rxtl_pkg::t_state   r_state, n_state;
    logic [RX_AW-1:0]   r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [TR_AW-1:0]   r_tr_wr, n_tr_wr, r_tr_rd, n_tr_rd;
    logic [rxtl_pkg::CNT_W-1:0] r_ovf, n_ovf, r_arr, n_arr;
    logic               r_o_valid, n_o_valid;
    rxtl_pkg::t_result  r_res, n_res, r_out, n_out;

    logic               in_beat;
    logic [RX_AW-1:0]   rx_head_nx, rx_tail_nx;
    logic [TR_AW-1:0]   tr_wr_nx, tr_rd_nx;
    logic               rx_we, tr_we, do_push;
    logic [RX_AW-1:0]   rx_addr;
    logic [TR_AW-1:0]   tr_addr;
    logic [rxtl_pkg::BYTE_W-1:0] rx_rdata;
    logic [TR_W-1:0]    tr_rdata_raw;
    rxtl_pkg::t_trace_entry tr_rdata, push_entry;

    assign rx_head_nx = (r_rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_head + 1'b1;
    assign rx_tail_nx = (r_rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : r_rx_tail + 1'b1;
    assign tr_wr_nx   = (r_tr_wr == TR_AW'(TRACE_DEPTH - 1)) ? '0 : r_tr_wr + 1'b1;
    assign tr_rd_nx   = (r_tr_rd == TR_AW'(TRACE_DEPTH - 1)) ? '0 : r_tr_rd + 1'b1;
    assign tr_rdata   = rxtl_pkg::t_trace_entry'(tr_rdata_raw);

    assign i_in.ready = (r_state == rxtl_pkg::S_IDLE);
    assign in_beat    = i_in.valid && i_in.ready;

    always_comb begin
        n_state    = r_state;
        n_rx_head  = r_rx_head;
        n_rx_tail  = r_rx_tail;
        n_tr_wr    = r_tr_wr;
        n_tr_rd    = r_tr_rd;
        n_ovf      = r_ovf;
        n_arr      = r_arr;
        n_res      = r_res;
        n_out      = r_out;
        n_o_valid  = r_o_valid && !o_out.ready;
        rx_we      = 1'b0;
        rx_addr    = r_rx_tail;
        tr_we      = 1'b0;
        tr_addr    = r_tr_rd;
        do_push    = 1'b0;
        push_entry = '0;

        case (r_state)
            rxtl_pkg::S_IDLE: begin
                if (in_beat) begin
                    n_res   = '0;
                    n_state = rxtl_pkg::S_RESP;
                    case (i_in.action)
                        rxtl_pkg::ACT_RX_BYTE: begin
                            if (!i_in.transmit_window) begin
                                if (rx_head_nx != r_rx_tail) begin
                                    rx_we     = 1'b1;
                                    rx_addr   = r_rx_head;
                                    n_rx_head = rx_head_nx;
                                end else begin
                                    n_ovf = r_ovf + 1'b1;
                                end
                                n_arr      = r_arr + 1'b1;
                                do_push    = 1'b1;
                                push_entry = '{kind: rxtl_pkg::KIND_DATA, is_tx: 1'b0,
                                               data: i_in.byte_value};
                            end
                        end
                        rxtl_pkg::ACT_TX_BYTE: begin
                            do_push    = 1'b1;
                            push_entry = '{kind: rxtl_pkg::KIND_DATA, is_tx: 1'b1,
                                           data: i_in.byte_value};
                        end
                        rxtl_pkg::ACT_TX_FEND: begin
                            do_push    = 1'b1;
                            push_entry = '{kind: rxtl_pkg::KIND_FEND, is_tx: 1'b1, data: '0};
                        end
                        rxtl_pkg::ACT_RX_FEND: begin
                            do_push    = 1'b1;
                            push_entry = '{kind: rxtl_pkg::KIND_FEND, is_tx: 1'b0, data: '0};
                        end
                        rxtl_pkg::ACT_READ: begin
                            if (r_rx_head != r_rx_tail) begin
                                n_rx_tail = rx_tail_nx;
                                n_state   = rxtl_pkg::S_RXRD;
                            end
                        end
                        rxtl_pkg::ACT_FLUSH: begin
                            n_rx_tail = r_rx_head;
                        end
                        rxtl_pkg::ACT_POP_EVENT: begin
                            if (r_tr_rd != r_tr_wr) begin
                                n_tr_rd = tr_rd_nx;
                                n_state = rxtl_pkg::S_TRRD;
                            end
                        end
                        rxtl_pkg::ACT_POP_DATA: begin
                            if (r_tr_rd != r_tr_wr) begin
                                n_tr_rd = tr_rd_nx;
                                n_state = rxtl_pkg::S_TRDATA;
                            end
                        end
                        rxtl_pkg::ACT_CLR_OVF: begin
                            n_ovf = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rxtl_pkg::S_RXRD: begin
                n_res.ok       = 1'b1;
                n_res.byte_out = rx_rdata;
                n_state        = rxtl_pkg::S_RESP;
            end
            rxtl_pkg::S_TRRD: begin
                n_res.ok          = 1'b1;
                n_res.byte_out    = tr_rdata.data;
                n_res.event_kind  = tr_rdata.kind;
                n_res.event_is_tx = tr_rdata.is_tx;
                n_state           = rxtl_pkg::S_RESP;
            end
            rxtl_pkg::S_TRDATA: begin
                if (tr_rdata.kind == rxtl_pkg::KIND_DATA) begin
                    n_res.ok          = 1'b1;
                    n_res.byte_out    = tr_rdata.data;
                    n_res.event_is_tx = tr_rdata.is_tx;
                    n_state           = rxtl_pkg::S_RESP;
                end else if (r_tr_rd != r_tr_wr) begin
                    // discard the frame end and fetch the next entry
                    n_tr_rd = tr_rd_nx;
                end else begin
                    n_state = rxtl_pkg::S_RESP;
                end
            end
            rxtl_pkg::S_RESP: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid            = 1'b1;
                    n_out                = r_res;
                    n_out.overflow_count = r_ovf;
                    n_out.received_count = r_arr;
                    n_state              = rxtl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rxtl_pkg::S_IDLE;
            end
        endcase

        if (do_push) begin
            tr_we   = 1'b1;
            tr_addr = r_tr_wr;
            n_tr_wr = tr_wr_nx;
            if (tr_wr_nx == r_tr_rd) begin
                n_tr_rd = tr_rd_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rxtl_pkg::S_IDLE;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_tr_wr   <= '0;
            r_tr_rd   <= '0;
            r_ovf     <= '0;
            r_arr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_tr_wr   <= n_tr_wr;
            r_tr_rd   <= n_tr_rd;
            r_ovf     <= n_ovf;
            r_arr     <= n_arr;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    rxtl_ram #(
        .WIDTH (rxtl_pkg::BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_addr  (rx_addr),
        .i_wdata (i_in.byte_value),
        .o_rdata (rx_rdata)
    );

    rxtl_ram #(
        .WIDTH (TR_W),
        .DEPTH (TRACE_DEPTH)
    ) u_trace_ram (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_addr  (tr_addr),
        .i_wdata (push_entry),
        .o_rdata (tr_rdata_raw)
    );

    assign o_out.valid          = r_o_valid;
    assign o_out.ok             = r_out.ok;
    assign o_out.byte_out       = r_out.byte_out;
    assign o_out.event_kind     = r_out.event_kind;
    assign o_out.event_is_tx    = r_out.event_is_tx;
    assign o_out.overflow_count = r_out.overflow_count;
    assign o_out.received_count = r_out.received_count;

    `include "rs485_rx_fifo_with_trace_log_top_macros.svh"

    `RXTL_ASSERT_NEXT(a_beat_leaves_idle, i_clk, i_rst_n, in_beat, r_state != rxtl_pkg::S_IDLE, "accepted beat did not start work")
    `RXTL_ASSERT_NEXT(a_clr_ovf, i_clk, i_rst_n, in_beat && (i_in.action == rxtl_pkg::ACT_CLR_OVF), r_ovf == '0, "overflow count not cleared")
    `RXTL_ASSERT_NEXT(a_push_not_empty, i_clk, i_rst_n, do_push, r_tr_wr != r_tr_rd, "trace ring empty right after a push")
    `RXTL_ASSERT_SAME(a_ram_single_write, i_clk, i_rst_n, rx_we, tr_we && (r_state == rxtl_pkg::S_IDLE), "rx store without its trace event")

endmodule

// File: rtl/rxtl_ram.sv
// ----------------------------------------------------------------------------
// rxtl_ram
// generic single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module rxtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: test/tb_rs485_rx_fifo_with_trace_log_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rs485_rx_fifo_with_trace_log_top
// self-checking bench for the rs485 receive ring and trace log. A short run of
// corner beats is followed by framed rx and tx traffic, ring drains, noise and
// one flood that wraps the trace ring. Every result beat is checked in order
// against a beat-level model of the receive ring, the trace ring and counters.
// ----------------------------------------------------------------------------
module tb_rs485_rx_fifo_with_trace_log_top;

    localparam int RX_DEPTH       = 2048;
    localparam int TRACE_DEPTH    = 512;
    localparam int RX_PTR_W       = $clog2(RX_DEPTH);
    localparam int TR_PTR_W       = $clog2(TRACE_DEPTH);
    localparam int RANDOM_BEATS   = 400;
    localparam int FLOOD_BEATS    = TRACE_DEPTH + 12;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [rxtl_pkg::ACT_W-1:0]  action;
        logic [rxtl_pkg::BYTE_W-1:0] byte_value;
        logic                        window;
        int                          phase;
        bit                          hold;
    } t_action_beat;

    logic i_clk;
    logic i_rst_n;

    rxtl_in_if  u_in_if ();
    rxtl_out_if u_out_if ();

    rs485_rx_fifo_with_trace_log_top #(
        .RX_DEPTH    (RX_DEPTH),
        .TRACE_DEPTH (TRACE_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    logic [rxtl_pkg::BYTE_W-1:0] rx_ring_mem [RX_DEPTH];
    logic [RX_PTR_W-1:0]         rx_wr_ptr;
    logic [RX_PTR_W-1:0]         rx_rd_ptr;
    logic [rxtl_pkg::CNT_W-1:0]  ovf_total;
    logic [rxtl_pkg::CNT_W-1:0]  arrival_total;
    rxtl_pkg::t_trace_entry      trace_mem [TRACE_DEPTH];
    logic [TR_PTR_W-1:0]         trace_wr_ptr;
    logic [TR_PTR_W-1:0]         trace_rd_ptr;

    t_action_beat      action_beats_q [$];
    rxtl_pkg::t_result exp_results_q [$];
    int                fill_phase;
    bit                hold_next;
    int                in_phase;
    int                rx_phase;
    int                mismatches;
    int                idle_cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic bit idle_roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [rxtl_pkg::BYTE_W-1:0] rand_byte();
        return rxtl_pkg::BYTE_W'($urandom_range(255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic void log_event(input logic kind, input logic is_tx,
                                      input logic [rxtl_pkg::BYTE_W-1:0] b);
        logic [TR_PTR_W-1:0] nxt;
        nxt = trace_wr_ptr + 1'b1;
        // full trace drops its oldest entry
        if (nxt == trace_rd_ptr)
            trace_rd_ptr = trace_rd_ptr + 1'b1;
        trace_mem[trace_wr_ptr] = {kind, is_tx, b};
        trace_wr_ptr = nxt;
    endfunction

    function automatic bit take_event(output rxtl_pkg::t_trace_entry e);
        e = '0;
        if (trace_rd_ptr == trace_wr_ptr)
            return 1'b0;
        e = trace_mem[trace_rd_ptr];
        trace_rd_ptr = trace_rd_ptr + 1'b1;
        return 1'b1;
    endfunction

    function automatic rxtl_pkg::t_result ring_trace_result(
        input logic [rxtl_pkg::ACT_W-1:0]  act,
        input logic [rxtl_pkg::BYTE_W-1:0] b,
        input logic                        win);
        rxtl_pkg::t_result      r;
        rxtl_pkg::t_trace_entry e;
        logic [RX_PTR_W-1:0]    nxt;
        bit                     found;
        r = '0;
        case (act)
            rxtl_pkg::ACT_RX_BYTE: begin
                if (!win) begin
                    nxt = rx_wr_ptr + 1'b1;
                    if (nxt != rx_rd_ptr) begin
                        rx_ring_mem[rx_wr_ptr] = b;
                        rx_wr_ptr = nxt;
                    end else begin
                        ovf_total = ovf_total + 1'b1;
                    end
                    arrival_total = arrival_total + 1'b1;
                    log_event(rxtl_pkg::KIND_DATA, 1'b0, b);
                end
            end
            rxtl_pkg::ACT_TX_BYTE: log_event(rxtl_pkg::KIND_DATA, 1'b1, b);
            rxtl_pkg::ACT_TX_FEND: log_event(rxtl_pkg::KIND_FEND, 1'b1, '0);
            rxtl_pkg::ACT_RX_FEND: log_event(rxtl_pkg::KIND_FEND, 1'b0, '0);
            rxtl_pkg::ACT_READ: begin
                if (rx_wr_ptr != rx_rd_ptr) begin
                    r.ok = 1'b1;
                    r.byte_out = rx_ring_mem[rx_rd_ptr];
                    rx_rd_ptr = rx_rd_ptr + 1'b1;
                end
            end
            rxtl_pkg::ACT_FLUSH: rx_rd_ptr = rx_wr_ptr;
            rxtl_pkg::ACT_POP_EVENT: begin
                if (take_event(e)) begin
                    r.ok = 1'b1;
                    r.byte_out = e.data;
                    r.event_kind = e.kind;
                    r.event_is_tx = e.is_tx;
                end
            end
            rxtl_pkg::ACT_POP_DATA: begin
                // frame ends on the way are consumed and dropped
                found = 1'b0;
                while (!found && take_event(e)) begin
                    if (e.kind == rxtl_pkg::KIND_DATA) begin
                        found = 1'b1;
                        r.ok = 1'b1;
                        r.byte_out = e.data;
                        r.event_is_tx = e.is_tx;
                    end
                end
            end
            rxtl_pkg::ACT_CLR_OVF: ovf_total = '0;
            default: ;
        endcase
        r.overflow_count = ovf_total;
        r.received_count = arrival_total;
        return r;
    endfunction

    function automatic void add_beat(input logic [rxtl_pkg::ACT_W-1:0] act,
                                     input logic [rxtl_pkg::BYTE_W-1:0] b,
                                     input logic win);
        t_action_beat beat;
        beat.action     = act;
        beat.byte_value = b;
        beat.window     = win;
        beat.phase      = fill_phase;
        beat.hold       = hold_next;
        hold_next       = 1'b0;
        action_beats_q.push_back(beat);
    endfunction

    function automatic void add_random_traffic(input int n_beats);
        int                          start;
        int                          pick;
        int                          len;
        logic [rxtl_pkg::BYTE_W-1:0] b;
        start = action_beats_q.size();
        while (action_beats_q.size() - start < n_beats) begin
            pick = $urandom_range(99);
            len  = $urandom_range(1, 8);
            if (pick < 30) begin
                // received frame
                repeat (len) add_beat(rxtl_pkg::ACT_RX_BYTE, rand_byte(), 1'b0);
                add_beat(rxtl_pkg::ACT_RX_FEND, rand_byte(), rand_bit());
            end else if (pick < 50) begin
                // transmitted frame with its own echo on the line
                repeat (len) begin
                    b = rand_byte();
                    add_beat(rxtl_pkg::ACT_TX_BYTE, b, 1'b1);
                    add_beat(rxtl_pkg::ACT_RX_BYTE, b, 1'b1);
                end
                add_beat(rxtl_pkg::ACT_TX_FEND, rand_byte(), 1'b1);
            end else if (pick < 80) begin
                repeat (len) begin
                    case ($urandom_range(2))
                        0:       add_beat(rxtl_pkg::ACT_READ, rand_byte(), rand_bit());
                        1:       add_beat(rxtl_pkg::ACT_POP_EVENT, rand_byte(), rand_bit());
                        default: add_beat(rxtl_pkg::ACT_POP_DATA, rand_byte(), rand_bit());
                    endcase
                end
            end else if (pick < 85) begin
                add_beat(rxtl_pkg::ACT_FLUSH, rand_byte(), rand_bit());
            end else if (pick < 88) begin
                add_beat(rxtl_pkg::ACT_CLR_OVF, rand_byte(), rand_bit());
            end else begin
                add_beat(rxtl_pkg::ACT_W'($urandom_range(15)), rand_byte(), rand_bit());
            end
        end
    endfunction

    // driver
    always @(posedge i_clk) begin : driver
        t_action_beat beat;
        if (!i_rst_n) begin
            u_in_if.valid <= 1'b0;
        end else if (!u_in_if.valid || u_in_if.ready) begin
            if (action_beats_q.size() != 0
                && !idle_roll(action_beats_q[0].phase == 0 ? 36 :
                              action_beats_q[0].phase == 1 ? 84 : 0)
                && !(action_beats_q[0].hold
                     && (u_in_if.valid || exp_results_q.size() != 0))) begin
                beat = action_beats_q.pop_front();
                u_in_if.valid           <= 1'b1;
                u_in_if.action          <= beat.action;
                u_in_if.byte_value      <= beat.byte_value;
                u_in_if.transmit_window <= beat.window;
                in_phase                <= beat.phase;
            end else begin
                u_in_if.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        rxtl_pkg::t_result want;
        rxtl_pkg::t_result got;
        if (!i_rst_n) begin
            u_out_if.ready <= 1'b0;
        end else begin
            if (u_out_if.valid && u_out_if.ready) begin
                got.ok             = u_out_if.ok;
                got.byte_out       = u_out_if.byte_out;
                got.event_kind     = u_out_if.event_kind;
                got.event_is_tx    = u_out_if.event_is_tx;
                got.overflow_count = u_out_if.overflow_count;
                got.received_count = u_out_if.received_count;
                if (exp_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat: ok=%0b byte=%02h", got.ok,
                                 got.byte_out);
                end else begin
                    want = exp_results_q.pop_front();
                    if (got.ok !== want.ok || got.byte_out !== want.byte_out
                        || got.event_kind !== want.event_kind
                        || got.event_is_tx !== want.event_is_tx
                        || got.overflow_count !== want.overflow_count
                        || got.received_count !== want.received_count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("result mismatch: expected ok=%0b byte=%02h kind=%0b tx=%0b ovf=%0d rcv=%0d",
                                     want.ok, want.byte_out, want.event_kind,
                                     want.event_is_tx, want.overflow_count,
                                     want.received_count);
                            $display("                 got      ok=%0b byte=%02h kind=%0b tx=%0b ovf=%0d rcv=%0d",
                                     got.ok, got.byte_out, got.event_kind,
                                     got.event_is_tx, got.overflow_count,
                                     got.received_count);
                        end
                    end
                end
            end
            if (u_in_if.valid && u_in_if.ready) begin
                exp_results_q.push_back(ring_trace_result(u_in_if.action,
                                                          u_in_if.byte_value,
                                                          u_in_if.transmit_window));
                rx_phase = in_phase;
            end
            u_out_if.ready <= !idle_roll(rx_phase == 0 ? 84 : rx_phase == 1 ? 36 : 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (u_in_if.valid && u_in_if.ready)
            || (u_out_if.valid && u_out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        i_rst_n                 = 1'b0;
        u_in_if.valid           = 1'b0;
        u_in_if.action          = '0;
        u_in_if.byte_value      = '0;
        u_in_if.transmit_window = 1'b0;
        u_out_if.ready          = 1'b0;
        rx_wr_ptr     = '0;
        rx_rd_ptr     = '0;
        ovf_total     = '0;
        arrival_total = '0;
        trace_wr_ptr  = '0;
        trace_rd_ptr  = '0;
        in_phase      = 0;
        rx_phase      = 0;
        mismatches    = 0;
        idle_cycles   = 0;

        fill_phase = 0;
        hold_next  = 1'b1;
        // empty rings
        add_beat(rxtl_pkg::ACT_READ, 8'h00, 1'b0);
        add_beat(rxtl_pkg::ACT_POP_EVENT, 8'h00, 1'b0);
        add_beat(rxtl_pkg::ACT_POP_DATA, 8'h00, 1'b0);
        // byte extremes, and a line byte inside the transmit window
        add_beat(rxtl_pkg::ACT_RX_BYTE, 8'h00, 1'b0);
        add_beat(rxtl_pkg::ACT_RX_BYTE, 8'hff, 1'b0);
        add_beat(rxtl_pkg::ACT_RX_BYTE, 8'ha5, 1'b1);
        add_beat(rxtl_pkg::ACT_TX_BYTE, 8'hff, 1'b0);
        add_beat(rxtl_pkg::ACT_TX_BYTE, 8'h00, 1'b1);
        add_beat(rxtl_pkg::ACT_TX_FEND, 8'hff, 1'b1);
        add_beat(rxtl_pkg::ACT_RX_FEND, 8'hff, 1'b0);
        add_beat(rxtl_pkg::ACT_READ, 8'hff, 1'b1);
        add_beat(rxtl_pkg::ACT_POP_EVENT, 8'h00, 1'b0);
        add_beat(rxtl_pkg::ACT_POP_DATA, 8'h00, 1'b0);
        add_beat(rxtl_pkg::ACT_POP_DATA, 8'h00, 1'b0);
        add_beat(rxtl_pkg::ACT_POP_DATA, 8'h00, 1'b0);
        // only frame ends left
        add_beat(rxtl_pkg::ACT_POP_DATA, 8'h00, 1'b0);
        add_beat(rxtl_pkg::ACT_RX_FEND, 8'h5a, 1'b1);
        add_beat(rxtl_pkg::ACT_POP_DATA, 8'hff, 1'b1);
        add_beat(rxtl_pkg::ACT_FLUSH, 8'h00, 1'b0);
        add_beat(rxtl_pkg::ACT_READ, 8'h00, 1'b0);
        add_beat(rxtl_pkg::ACT_CLR_OVF, 8'hff, 1'b1);
        // unused codes
        add_beat(4'd9, 8'hff, 1'b1);
        add_beat(4'd15, 8'h00, 1'b0);
        add_random_traffic(RANDOM_BEATS / 3);

        fill_phase = 1;
        hold_next  = 1'b1;
        add_random_traffic(RANDOM_BEATS / 3);

        fill_phase = 2;
        hold_next  = 1'b1;
        // wrap the trace ring past full
        repeat (FLOOD_BEATS) add_beat(rxtl_pkg::ACT_RX_BYTE, rand_byte(), 1'b0);
        add_random_traffic(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (action_beats_q.size() != 0 || u_in_if.valid || exp_results_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && exp_results_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rxtl_pkg.sv
rtl/rxtl_if.sv
rtl/rxtl_ram.sv
rtl/rs485_rx_fifo_with_trace_log_top.sv
test/tb_rs485_rx_fifo_with_trace_log_top.sv
